@@ hw/rtl/wysl_pkg.sv @@
// ----------------------------------------------------------------------------
// wysl_pkg
// Shared widths, constants and types of the wrapped yaw slew limiter.
// ----------------------------------------------------------------------------
package wysl_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int TIME_BITS  = 32;
  localparam int LIMIT_BITS = 20;
  localparam int RATE_BITS  = 21;

  // clamped dt, 1000..50000 us
  localparam int DT_W = 16;
  // step limit and signed step carry one bit over an angle
  localparam int MSTEP_W = ANGLE_BITS + 1;

  // rate divider: 36-bit dividend (|step| * 1e6), 20-bit divisor (dt)
  localparam int DVD_W       = 36;
  localparam int DVS_W       = 20;
  localparam int DIV_STEPS   = DVD_W / 2;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // step limit: floor(p / 1e6) = floor((p >> 6) / 15625); the second
  // division is a multiply by ceil(2^44 / 15625), exact for 30-bit operands
  localparam int SCALED_W    = DVD_W - 6;
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 44;
  localparam logic [RECIP_W-1:0] STEP_RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd15624) / 64'd15625);

  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 1));

  // 0.1 rad/s in binary-angle units per second
  localparam logic [LIMIT_BITS-1:0] MIN_RATE =
    LIMIT_BITS'(((64'd1 << ANGLE_BITS) * 64'd1000000) / 64'd62831853);
  localparam logic [LIMIT_BITS-1:0] RATE_LIMIT_RESET = LIMIT_BITS'(20861);

  localparam logic [DT_W-1:0]  DT_MIN       = DT_W'(1000);
  localparam logic [DT_W-1:0]  DT_MAX       = DT_W'(50000);
  localparam logic [DVS_W-1:0] USEC_PER_SEC = DVS_W'(1000000);

  localparam logic [DVD_W-1:0] RATE_POS_MAG = DVD_W'((64'd1 << (RATE_BITS - 1)) - 64'd1);
  localparam logic [DVD_W-1:0] RATE_NEG_MAG = DVD_W'(64'd1 << (RATE_BITS - 1));
  localparam logic signed [RATE_BITS-1:0] RATE_POS_SAT = {1'b0, {(RATE_BITS-1){1'b1}}};
  localparam logic signed [RATE_BITS-1:0] RATE_NEG_SAT = {1'b1, {(RATE_BITS-1){1'b0}}};

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ENABLE = 1'b1;

  typedef struct packed {
    logic                         kind;
    logic                         enable;
    logic [ANGLE_BITS-1:0]        setpoint_yaw;
    logic                         setpoint_valid;
    logic signed [RATE_BITS-1:0]  setpoint_rate;
    logic [ANGLE_BITS-1:0]        measured_yaw;
    logic                         measured_valid;
    logic [TIME_BITS-1:0]         now_us;
    logic                         time_valid;
  } in_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_STEP,
    ST_DIV_STEP,
    ST_CLAMP,
    ST_MUL_RATE,
    ST_DIV_RATE,
    ST_WAIT_RATE,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic load_dt;
    logic mul_step;
    logic div_step;
    logic load_clamp;
    logic mul_rate;
    logic div_rate;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic slew;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/wysl_div.sv @@
// ----------------------------------------------------------------------------
// wysl_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module wysl_div import wysl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     qsh;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     dvs;

  logic [DVS_W:0]   r1, r2, sub1, sub2;
  logic             ge1, ge2;
  logic [DVS_W-1:0] rem1, rem2;

  always_comb begin
    r1   = {rem, qsh[DVD_W-1]};
    sub1 = r1 - {1'b0, dvs};
    ge1  = r1 >= {1'b0, dvs};
    rem1 = ge1 ? sub1[DVS_W-1:0] : r1[DVS_W-1:0];
    r2   = {rem1, qsh[DVD_W-2]};
    sub2 = r2 - {1'b0, dvs};
    ge2  = r2 >= {1'b0, dvs};
    rem2 = ge2 ? sub2[DVS_W-1:0] : r2[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      qsh <= {qsh[DVD_W-3:0], ge1, ge2};
      rem <= rem2;
    end
  end

  assign quotient = qsh;

endmodule

@@ hw/rtl/wysl_dp.sv @@
// ----------------------------------------------------------------------------
// wysl_dp
// Datapath: servo state, dt clamp, step limit, clamp, rate and result register.
// ----------------------------------------------------------------------------
module wysl_dp import wysl_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  in_item_t                    s_item,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  input  logic                        cfg_we,
  input  logic [LIMIT_BITS-1:0]       cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ANGLE_BITS-1:0]       out_yaw,
  output logic signed [RATE_BITS-1:0] out_rate
);

  in_item_t              item;
  logic [LIMIT_BITS-1:0] rate_limit;
  logic                  servo_active;
  logic                  servo_initialized;
  logic [ANGLE_BITS-1:0] held_yaw;
  logic [TIME_BITS-1:0]  last_time_us;

  logic [DT_W-1:0]          dt;
  logic [LIMIT_BITS-1:0]    lim;
  logic [DVD_W-1:0]         prod;
  logic [MSTEP_W-1:0]       lim_step;
  logic signed [MSTEP_W-1:0] step;
  logic [MSTEP_W-1:0]       mag;

  logic [DVD_W-1:0] div_quot;
  logic             div_done;
  logic             div_start;
  logic [DVS_W-1:0] div_divisor;

  wysl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign div_start   = cmd.div_rate;
  assign div_divisor = DVS_W'(dt);

  // step limit, floor(lim * dt / 1e6) by reciprocal multiply
  logic [SCALED_W+RECIP_W-1:0] recip_prod;

  assign recip_prod = prod[DVD_W-1:DVD_W-SCALED_W] * STEP_RECIP;

  // elapsed time, clamped
  logic [TIME_BITS-1:0]  diff_t;
  logic [DT_W-1:0]       dt_next;
  logic [LIMIT_BITS-1:0] lim_next;

  always_comb begin
    diff_t = item.now_us - last_time_us;
    if (diff_t[TIME_BITS-1]) begin
      dt_next = DT_MIN;
    end else if (diff_t < TIME_BITS'(DT_MIN)) begin
      dt_next = DT_MIN;
    end else if (diff_t > TIME_BITS'(DT_MAX)) begin
      dt_next = DT_MAX;
    end else begin
      dt_next = diff_t[DT_W-1:0];
    end
    lim_next = (rate_limit < MIN_RATE) ? MIN_RATE : rate_limit;
  end

  // wrapped difference and clamp to the step limit
  logic [ANGLE_BITS-1:0]     d_ang;
  logic signed [MSTEP_W-1:0] delta;
  logic signed [MSTEP_W:0]   delta_x, ms_x, ms_neg, step_x;
  logic signed [MSTEP_W-1:0] step_next;
  logic [MSTEP_W-1:0]        mag_next;

  always_comb begin
    d_ang = item.setpoint_yaw - held_yaw;
    // half a turn counts as positive
    delta   = (d_ang > HALF_TURN) ? {1'b1, d_ang} : {1'b0, d_ang};
    delta_x = {delta[MSTEP_W-1], delta};
    ms_x    = {1'b0, lim_step};
    ms_neg  = -ms_x;
    if (delta_x > ms_x) begin
      step_x = ms_x;
    end else if (delta_x < ms_neg) begin
      step_x = ms_neg;
    end else begin
      step_x = delta_x;
    end
    step_next = step_x[MSTEP_W-1:0];
    mag_next  = step_next[MSTEP_W-1] ? MSTEP_W'(-step_next) : MSTEP_W'(step_next);
  end

  logic [LIMIT_BITS+DT_W-1:0]    prod_step;
  logic [MSTEP_W+DVS_W-1:0]      prod_rate;

  assign prod_step = lim * dt;
  assign prod_rate = mag * USEC_PER_SEC;

  // result selection and next servo state
  logic                        active_n, init_n;
  logic [ANGLE_BITS-1:0]       held_n, yaw_o;
  logic [TIME_BITS-1:0]        last_n;
  logic signed [RATE_BITS-1:0] rate_o, slew_rate;
  logic [ANGLE_BITS-1:0]       meas_or_zero;

  always_comb begin
    if (!step[MSTEP_W-1]) begin
      slew_rate = (div_quot > RATE_POS_MAG) ? RATE_POS_SAT : div_quot[RATE_BITS-1:0];
    end else begin
      slew_rate = (div_quot > RATE_NEG_MAG) ? RATE_NEG_SAT : -div_quot[RATE_BITS-1:0];
    end
  end

  always_comb begin
    meas_or_zero = item.measured_valid ? item.measured_yaw : '0;
    active_n     = servo_active;
    init_n       = servo_initialized;
    held_n       = held_yaw;
    last_n       = last_time_us;
    yaw_o        = held_yaw;
    rate_o       = '0;
    priority if (item.kind == KIND_ENABLE) begin
      if (item.enable && !servo_active) begin
        held_n = meas_or_zero;
        init_n = 1'b0;
      end
      active_n = item.enable;
      yaw_o    = held_n;
    end else if (!servo_active) begin
      yaw_o  = item.setpoint_yaw;
      rate_o = item.setpoint_rate;
    end else if (!item.setpoint_valid) begin
      yaw_o = servo_initialized ? held_yaw : meas_or_zero;
    end else if (!servo_initialized || !item.time_valid) begin
      held_n = item.measured_valid ? item.measured_yaw : item.setpoint_yaw;
      if (item.time_valid) begin
        init_n = 1'b1;
        last_n = item.now_us;
      end else begin
        init_n = 1'b0;
      end
      yaw_o = held_n;
    end else begin
      held_n = held_yaw + step[ANGLE_BITS-1:0];
      last_n = item.now_us;
      yaw_o  = held_n;
      rate_o = slew_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_limit        <= RATE_LIMIT_RESET;
      servo_active      <= 1'b0;
      servo_initialized <= 1'b0;
      held_yaw          <= '0;
      last_time_us      <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_limit <= cfg_wdata;
      end
      if (cmd.commit) begin
        servo_active      <= active_n;
        servo_initialized <= init_n;
        held_yaw          <= held_n;
        last_time_us      <= last_n;
        out_valid         <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= s_item;
    end
    if (cmd.load_dt) begin
      dt  <= dt_next;
      lim <= lim_next;
    end
    if (cmd.mul_step) begin
      prod <= prod_step;
    end else if (cmd.mul_rate) begin
      prod <= prod_rate[DVD_W-1:0];
    end
    if (cmd.div_step) begin
      lim_step <= recip_prod[RECIP_SHIFT+MSTEP_W-1:RECIP_SHIFT];
    end
    if (cmd.load_clamp) begin
      step <= step_next;
      mag  <= mag_next;
    end
    if (cmd.commit) begin
      out_yaw  <= yaw_o;
      out_rate <= rate_o;
    end
  end

  assign status.slew     = (item.kind == KIND_SAMPLE) && servo_active && item.setpoint_valid &&
                           servo_initialized && item.time_valid;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ hw/rtl/wysl_ctrl.sv @@
// ----------------------------------------------------------------------------
// wysl_ctrl
// Controller: sequences capture, step limit, clamp, rate divide and commit.
// ----------------------------------------------------------------------------
module wysl_ctrl import wysl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE:    state_next = status.slew ? ST_MUL_STEP : ST_FINISH;
      ST_MUL_STEP:  state_next = ST_DIV_STEP;
      ST_DIV_STEP:  state_next = ST_CLAMP;
      ST_CLAMP:     state_next = ST_MUL_RATE;
      ST_MUL_RATE:  state_next = ST_DIV_RATE;
      ST_DIV_RATE:  state_next = ST_WAIT_RATE;
      ST_WAIT_RATE: if (status.div_done) state_next = ST_FINISH;
      ST_FINISH:    if (status.out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECIDE:    cmd.load_dt    = 1'b1;
      ST_MUL_STEP:  cmd.mul_step   = 1'b1;
      ST_DIV_STEP:  cmd.div_step   = 1'b1;
      ST_CLAMP:     cmd.load_clamp = 1'b1;
      ST_MUL_RATE:  cmd.mul_rate   = 1'b1;
      ST_DIV_RATE:  cmd.div_rate   = 1'b1;
      ST_WAIT_RATE: cmd            = '0;
      ST_FINISH:    cmd.commit     = status.out_free;
      default:      cmd            = '0;
    endcase
  end

endmodule

@@ hw/rtl/wrapped_yaw_slew_limiter_unit.sv @@
// ----------------------------------------------------------------------------
// wrapped_yaw_slew_limiter_unit
// Slews a held binary-angle heading toward a yaw setpoint at a limited rate.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: kind; s_tdata: sample fields
// m_*       out  m_tvalid/m_tready  m_tdata: out_yaw, out_rate
// cfg_*     in   cfg_we             cfg_wdata: rate_limit
//
// One input transaction at a time. From acceptance until the result register
// is loaded, enable items and samples that skip the slew pass only through
// the decide and commit steps. A slewing sample runs six steps (decide, two
// multiplies, the reciprocal step limit, clamp, divider start), then waits on
// the 2-bit-per-cycle rate divider, and then commits. A new input transaction
// is taken as soon as the previous result sits in the output register, even
// if m_tready is low; the result of the next one waits until that register
// is free. Reset (rst, synchronous) restores the rate limit to 20861 and
// clears the servo state.
// ----------------------------------------------------------------------------
module wrapped_yaw_slew_limiter_unit import wysl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata, lowest bit up: enable[0], setpoint_yaw[16:1], setpoint_valid[17],
  // setpoint_rate[38:18], measured_yaw[54:39], measured_valid[55],
  // now_us[87:56], time_valid[88], zero pad [95:89]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [95:0]           s_tdata,
  // s_tuser: kind[0]
  input  logic [0:0]            s_tuser,
  // m_tdata, lowest bit up: out_yaw[15:0], out_rate[36:16], zero pad [39:37]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,
  input  logic                  cfg_we,
  input  logic [LIMIT_BITS-1:0] cfg_wdata
);

  in_item_t   s_item;
  dp_cmd_t    cmd;
  dp_status_t status;

  logic [ANGLE_BITS-1:0]       out_yaw;
  logic signed [RATE_BITS-1:0] out_rate;

  // unpack the input transaction
  always_comb begin
    s_item.kind           = s_tuser[0];
    s_item.enable         = s_tdata[0];
    s_item.setpoint_yaw   = s_tdata[16:1];
    s_item.setpoint_valid = s_tdata[17];
    s_item.setpoint_rate  = s_tdata[38:18];
    s_item.measured_yaw   = s_tdata[54:39];
    s_item.measured_valid = s_tdata[55];
    s_item.now_us         = s_tdata[87:56];
    s_item.time_valid     = s_tdata[88];
  end

  wysl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wysl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_item    (s_item),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_yaw   (out_yaw),
    .out_rate  (out_rate)
  );

  assign m_tdata = {3'b000, out_rate, out_yaw};

endmodule
